// ===== rtl/core/bei_pkg.sv =====
package bei_pkg;

  // fixed field widths
  localparam int FIELD_TICK_W = 24;
  localparam int LEVEL_W      = 16;
  localparam int VAL_W        = LEVEL_W + 1;
  localparam int FRAC_W       = 15;
  localparam int LEVEL_ONE    = 32768;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT = 1'b1;

  // interpolation modes
  localparam logic [1:0] MODE_STEP   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;

  // input opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LERP,
    S_MUL,
    S_SUM
  } bei_state_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL,
    L_DIV,
    L_DONE
  } bei_lerp_state_t;

endpackage

// ===== rtl/core/bei_lerp.sv =====
// bit-serial a + num * (b - a) / den, quotient truncated toward zero
module bei_lerp import bei_pkg::*; #(
  parameter int TW = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  input  logic        [TW-1:0]    num,
  input  logic        [TW-1:0]    den,
  output logic                    done,
  output logic signed [VAL_W-1:0] res
);

  localparam int MW   = LEVEL_W;
  localparam int PW   = TW + MW;
  localparam int CNTW = $clog2(PW + 1);

  bei_lerp_state_t st_r, st_nxt;

  logic        [CNTW-1:0]  cnt_r;
  logic        [PW-1:0]    mcand_r;
  logic        [MW-1:0]    mplier_r;
  logic        [PW-1:0]    prod_r;
  logic        [TW-1:0]    rem_r;
  logic        [MW-1:0]    quo_r;
  logic        [TW-1:0]    den_r;
  logic signed [VAL_W-1:0] a_r;
  logic                    neg_r;

  logic signed [VAL_W:0]   diff;
  logic        [VAL_W:0]   mag;
  logic        [TW:0]      trial;
  logic        [TW:0]      sub;
  logic                    qbit;

  always_comb begin
    diff  = (VAL_W+1)'(b) - (VAL_W+1)'(a);
    mag   = diff[VAL_W] ? (VAL_W+1)'(-diff) : (VAL_W+1)'(diff);
    trial = {rem_r, prod_r[PW-1]};
    sub   = trial - {1'b0, den_r};
    qbit  = (trial >= {1'b0, den_r});
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      L_IDLE: if (start) st_nxt = L_MUL;
      L_MUL:  if (cnt_r == CNTW'(MW - 1)) st_nxt = L_DIV;
      L_DIV:  if (cnt_r == CNTW'(PW - 1)) st_nxt = L_DONE;
      L_DONE: st_nxt = L_IDLE;
      default: st_nxt = L_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done = (st_r == L_DONE);
    res  = neg_r ? VAL_W'(a_r - signed'({1'b0, quo_r}))
                 : VAL_W'(a_r + signed'({1'b0, quo_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      L_IDLE: begin
        if (start) begin
          mcand_r  <= PW'(num);
          mplier_r <= mag[MW-1:0];
          prod_r   <= '0;
          rem_r    <= '0;
          neg_r    <= diff[VAL_W];
          a_r      <= a;
          den_r    <= den;
          cnt_r    <= '0;
        end
      end
      L_MUL: begin
        if (mplier_r[0]) prod_r <= prod_r + mcand_r;
        mcand_r  <= {mcand_r[PW-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[MW-1:1]};
        cnt_r    <= (cnt_r == CNTW'(MW - 1)) ? '0 : cnt_r + 1'b1;
      end
      L_DIV: begin
        rem_r  <= qbit ? sub[TW-1:0] : trial[TW-1:0];
        prod_r <= {prod_r[PW-2:0], 1'b0};
        quo_r  <= {quo_r[MW-2:0], qbit};
        cnt_r  <= cnt_r + 1'b1;
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/breakpoint_envelope_interpolator.sv =====
// Breakpoint envelope interpolator: keeps a table of up to MAX_POINTS breakpoints
// (tick, Q1.15 level, signed Q1.15 depth) loaded by write transactions, and answers
// query transactions with the envelope level at a tick, step-held or linearly
// interpolated between the bracketing points, plus depth times the modulator
// sample, clamped to 0..1.0. For a query the table is scanned one entry per cycle
// through the single registered read port of the breakpoint memory; when the query
// needs interpolation, two bit-serial units (one for level, one for depth) then run
// a shift-add multiply followed by a restoring divide. One query is in flight at a
// time; its result sits in an output register so the next transaction is taken
// while it waits. Queries before the first point or on an empty table return
// level 0 with level_valid low.
module breakpoint_envelope_interpolator import bei_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int TICK_BITS  = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           cfg_we,
  input  logic        [CFG_IDX_W-1:0]    cfg_index,
  input  logic        [CFG_DATA_W-1:0]   cfg_wdata,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_opcode,
  input  logic        [5:0]              in_point_index,
  input  logic        [FIELD_TICK_W-1:0] in_point_tick,
  input  logic        [LEVEL_W-1:0]      in_point_level,
  input  logic signed [LEVEL_W-1:0]      in_point_depth,
  input  logic        [FIELD_TICK_W-1:0] in_query_tick,
  input  logic signed [LEVEL_W-1:0]      in_lfo_sample,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic        [LEVEL_W-1:0]      out_level,
  output logic                           out_level_valid
);

  // effective tick width: ticks are masked to TICK_BITS, ports are fixed
  localparam int TW    = (TICK_BITS < FIELD_TICK_W) ? TICK_BITS : FIELD_TICK_W;
  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int EW    = TW + 2 * LEVEL_W;
  localparam int TOT_W = 2 * LEVEL_W + 2;

  bei_state_t st_r, st_nxt;

  // configuration registers
  logic [1:0]            mode_r;
  logic [CFG_DATA_W-1:0] count_r;

  // breakpoint memory, one word per point: {tick, level, depth}
  logic [EW-1:0] mem [MAX_POINTS];
  logic [EW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          slot_ok;

  // handshake and control strobes
  logic in_acc;
  logic mem_we;
  logic scan_issue;
  logic scan_end;
  logic interp;
  logic lerp_start;
  logic out_load;
  logic lvl_done;
  logic dep_done;

  // query context
  logic        [TW-1:0]      q_r;
  logic signed [LEVEL_W-1:0] lfo_r;
  logic        [CW-1:0]      n_r;
  logic        [CW-1:0]      n_clamp;
  logic        [CW-1:0]      iss_r;
  logic                      rvld_r;

  // scan results: latest point at or before the tick, and the slot after it
  logic                      found_r;
  logic                      pend_r;
  logic                      nxt_ok_r;
  logic        [TW-1:0]      p_tick_r;
  logic        [LEVEL_W-1:0] p_lvl_r;
  logic signed [LEVEL_W-1:0] p_dep_r;
  logic        [TW-1:0]      n_tick_r;
  logic        [LEVEL_W-1:0] n_lvl_r;
  logic signed [LEVEL_W-1:0] n_dep_r;

  logic        [TW-1:0]      rd_tick;
  logic        [LEVEL_W-1:0] rd_lvl;
  logic signed [LEVEL_W-1:0] rd_dep;

  // interpolation and modulation
  logic signed [VAL_W-1:0]     lvl_res;
  logic signed [VAL_W-1:0]     dep_res;
  logic signed [VAL_W-1:0]     v_r;
  logic signed [VAL_W-1:0]     d_r;
  logic signed [2*LEVEL_W-1:0] mprod_r;
  logic signed [TOT_W-1:0]     total;
  logic signed [TOT_W-1:0]     shifted;
  logic        [LEVEL_W-1:0]   level_c;

  logic                 out_valid_r;
  logic [LEVEL_W-1:0]   out_level_r;
  logic                 out_level_valid_r;

  assign out_valid       = out_valid_r;
  assign out_level       = out_level_r;
  assign out_level_valid = out_level_valid_r;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_LINEAR;
      count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_MODE:  mode_r  <= cfg_wdata[1:0];
        CFG_IDX_COUNT: count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a count above the table size acts as the table size
  always_comb begin
    if (32'(count_r) > MAX_POINTS) n_clamp = CW'(MAX_POINTS);
    else                           n_clamp = CW'(count_r);
  end

  // ---------------------------------------------------------------------------
  // breakpoint memory
  // ---------------------------------------------------------------------------
  assign in_acc  = in_valid && in_ready;
  assign slot_ok = (32'(in_point_index) < MAX_POINTS);
  assign wr_addr = AW'(in_point_index);
  assign wr_data = {in_point_tick[TW-1:0], in_point_level, in_point_depth};
  assign rd_addr = iss_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  assign rd_tick = rd_data_r[EW-1 -: TW];
  assign rd_lvl  = rd_data_r[2*LEVEL_W-1 -: LEVEL_W];
  assign rd_dep  = rd_data_r[LEVEL_W-1:0];

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  // all fetched entries checked once nothing is left to issue or in flight
  assign scan_end = !rvld_r && !(iss_r < n_r);
  // interpolate only strictly between a point and the slot after it, and not in step mode
  assign interp   = nxt_ok_r && (p_tick_r != q_r) && (mode_r != MODE_STEP);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_acc && (in_opcode == OP_QUERY)) st_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_end) begin
          if (!found_r)    st_nxt = S_SUM;
          else if (interp) st_nxt = S_LERP;
          else             st_nxt = S_MUL;
        end
      end
      S_LERP: begin
        if (lvl_done) st_nxt = S_MUL;
      end
      S_MUL: st_nxt = S_SUM;
      S_SUM: begin
        if (!out_valid_r || out_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = (st_r == S_IDLE);
    mem_we     = in_valid && (st_r == S_IDLE) && (in_opcode == OP_WRITE) && slot_ok;
    scan_issue = (st_r == S_SCAN) && (iss_r < n_r);
    lerp_start = (st_r == S_SCAN) && scan_end && found_r && interp;
    out_load   = (st_r == S_SUM) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      rvld_r <= scan_issue;
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // table scan, one entry per cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc && (in_opcode == OP_QUERY)) begin
      q_r      <= in_query_tick[TW-1:0];
      lfo_r    <= in_lfo_sample;
      n_r      <= n_clamp;
      iss_r    <= '0;
      found_r  <= 1'b0;
      pend_r   <= 1'b0;
      nxt_ok_r <= 1'b0;
    end else begin
      if (scan_issue) iss_r <= iss_r + 1'b1;
      if (rvld_r) begin
        if (rd_tick <= q_r) begin
          // new candidate: the slot after it is the upper bracket
          found_r  <= 1'b1;
          pend_r   <= 1'b1;
          nxt_ok_r <= 1'b0;
          p_tick_r <= rd_tick;
          p_lvl_r  <= rd_lvl;
          p_dep_r  <= rd_dep;
        end else if (pend_r) begin
          pend_r   <= 1'b0;
          nxt_ok_r <= 1'b1;
          n_tick_r <= rd_tick;
          n_lvl_r  <= rd_lvl;
          n_dep_r  <= rd_dep;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // interpolation: level and depth lanes run side by side
  // ---------------------------------------------------------------------------
  bei_lerp #(.TW(TW)) u_lerp_level (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .a     (signed'({1'b0, p_lvl_r})),
    .b     (signed'({1'b0, n_lvl_r})),
    .num   (q_r - p_tick_r),
    .den   (n_tick_r - p_tick_r),
    .done  (lvl_done),
    .res   (lvl_res)
  );

  bei_lerp #(.TW(TW)) u_lerp_depth (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .a     (VAL_W'(p_dep_r)),
    .b     (VAL_W'(n_dep_r)),
    .num   (q_r - p_tick_r),
    .den   (n_tick_r - p_tick_r),
    .done  (dep_done),
    .res   (dep_res)
  );

  // ---------------------------------------------------------------------------
  // modulation and clamp
  // ---------------------------------------------------------------------------
  always_comb begin
    total   = (TOT_W'(v_r) <<< FRAC_W) + TOT_W'(mprod_r);
    shifted = total >>> FRAC_W;
    if (!found_r || (total <= 0))           level_c = '0;
    else if (shifted > TOT_W'(LEVEL_ONE))   level_c = LEVEL_W'(LEVEL_ONE);
    else                                    level_c = shifted[LEVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    // held point, taken when no interpolation is needed
    if ((st_r == S_SCAN) && scan_end && !interp) begin
      v_r <= signed'({1'b0, p_lvl_r});
      d_r <= VAL_W'(p_dep_r);
    end
    // both lanes finish together
    if ((st_r == S_LERP) && lvl_done && dep_done) begin
      v_r <= lvl_res;
      d_r <= dep_res;
    end
    if (st_r == S_MUL) mprod_r <= signed'(d_r[LEVEL_W-1:0]) * lfo_r;
    if (out_load) begin
      out_level_r       <= level_c;
      out_level_valid_r <= found_r;
    end
  end

endmodule
